// ===== hw/rtl/tod_pkg.sv =====
// tod_pkg: shared types, operation codes and constants for the time-of-day accumulator
// used by tod_split, time_of_day_accumulator_core and tod_checker; no dependencies
package tod_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD_MS  = 2'd0;
    localparam logic [1:0] OP_ADD_SEC = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;

    localparam int unsigned MS_PER_SEC    = 1000;
    localparam int unsigned SEC_PER_MIN   = 60;
    localparam int unsigned MIN_PER_HOUR  = 60;
    localparam int unsigned HOURS_PER_DAY = 24;
    localparam int unsigned MS_PER_MIN    = MS_PER_SEC * SEC_PER_MIN;
    localparam int unsigned MS_PER_HOUR   = MS_PER_MIN * MIN_PER_HOUR;
    localparam int unsigned MAX_HOUR      = 23;
    localparam int unsigned MAX_MINUTE    = 59;
    localparam int unsigned MAX_SECOND    = 59;
    localparam int unsigned MAX_MILLIS    = 999;

    // reciprocal constants: floor(z / d) == (z * MAGIC) >> SHIFT over the ranges used
    localparam int unsigned MAGIC_DIV125 = 274877907;  // d = 125, after a shift by 3
    localparam int unsigned SHIFT_DIV125 = 35;
    localparam int unsigned MAGIC_DIV15  = 572662307;  // d = 15, after a shift by 2
    localparam int unsigned SHIFT_DIV15  = 33;
    localparam int unsigned MAGIC_DIV3   = 87382;      // d = 3, after a shift by 3
    localparam int unsigned SHIFT_DIV3   = 18;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [30:0] delta_amount;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
        logic [9:0]  load_millis;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [9:0]  cur_millis;
        logic [26:0] day_millis;
        logic        accepted;
    } out_item_t;

    // checked load values carried down the split pipeline
    typedef struct packed {
        logic       ok;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] millis;
    } load_t;

    // per-item update: digit deltas for adds, new time for loads
    typedef struct packed {
        logic [1:0] opcode;
        logic       accepted;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] millis;
    } step_t;

endpackage

// ===== hw/rtl/tod_split.sv =====
// tod_split: pipeline that breaks an add amount into hour/minute/second/millisecond digits
// modulo one day, and checks load fields; depends on tod_pkg
module tod_split (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  tod_pkg::in_item_t in_item,
    output logic              out_valid,
    output tod_pkg::step_t    out_step
);
    import tod_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vout_reg;

    // stage 1: captured item
    logic [1:0]  op1_reg;
    logic [30:0] amt1_reg;
    load_t       ld1_reg;
    load_t       ld_in;
    logic [56:0] prod_ms;
    logic [21:0] qms;

    // stage 2: whole seconds of a millisecond add
    logic [1:0]  op2_reg;
    logic [30:0] amt2_reg;
    logic [21:0] qms2_reg;
    load_t       ld2_reg;
    logic [30:0] rem_ms;
    logic [30:0] sec_total;
    logic [9:0]  dms;
    logic [58:0] prod_min;
    logic [25:0] mq;

    // stage 3: total seconds and total minutes
    logic [1:0]  op3_reg;
    logic [30:0] sec3_reg;
    logic [25:0] mq3_reg;
    logic [9:0]  dms3_reg;
    load_t       ld3_reg;
    logic [30:0] rem_sec;
    logic [53:0] prod_hour;
    logic [19:0] hq;

    // stage 4: total minutes and total hours
    logic [1:0]  op4_reg;
    logic [25:0] mq4_reg;
    logic [19:0] hq4_reg;
    logic [9:0]  dms4_reg;
    logic [5:0]  ds4_reg;
    load_t       ld4_reg;
    logic [25:0] rem_min;
    logic [33:0] prod_day;
    logic [14:0] hd;

    // stage 5: total hours and whole days
    logic [1:0]  op5_reg;
    logic [19:0] hq5_reg;
    logic [14:0] hd5_reg;
    logic [9:0]  dms5_reg;
    logic [5:0]  ds5_reg;
    logic [5:0]  dm5_reg;
    load_t       ld5_reg;
    logic [19:0] rem_hour;
    step_t       step_next;
    step_t       step_reg;

    assign ld_in.ok = (in_item.load_hour < 5'(HOURS_PER_DAY))
                   && (in_item.load_minute < 6'(MIN_PER_HOUR))
                   && (in_item.load_second < 6'(SEC_PER_MIN))
                   && (in_item.load_millis < 10'(MS_PER_SEC));
    assign ld_in.hour   = in_item.load_hour;
    assign ld_in.minute = in_item.load_minute;
    assign ld_in.second = in_item.load_second;
    assign ld_in.millis = in_item.load_millis;

    // x / 1000 as (x >> 3) / 125
    assign prod_ms = 57'(amt1_reg[30:3]) * 57'(MAGIC_DIV125);
    assign qms     = prod_ms[SHIFT_DIV125 +: 22];

    assign rem_ms    = amt2_reg - 31'(qms2_reg) * 31'(MS_PER_SEC);
    assign sec_total = (op2_reg == OP_ADD_MS) ? 31'(qms2_reg) : amt2_reg;
    assign dms       = (op2_reg == OP_ADD_MS) ? rem_ms[9:0] : '0;
    // s / 60 as (s >> 2) / 15
    assign prod_min  = 59'(sec_total[30:2]) * 59'(MAGIC_DIV15);
    assign mq        = prod_min[SHIFT_DIV15 +: 26];

    assign rem_sec   = sec3_reg - 31'(mq3_reg) * 31'(SEC_PER_MIN);
    assign prod_hour = 54'(mq3_reg[25:2]) * 54'(MAGIC_DIV15);
    assign hq        = prod_hour[SHIFT_DIV15 +: 20];

    assign rem_min   = mq4_reg - 26'(hq4_reg) * 26'(MIN_PER_HOUR);
    // h / 24 as (h >> 3) / 3
    assign prod_day  = 34'(hq4_reg[19:3]) * 34'(MAGIC_DIV3);
    assign hd        = prod_day[SHIFT_DIV3 +: 15];

    assign rem_hour  = hq5_reg - 20'(hd5_reg) * 20'(HOURS_PER_DAY);

    always_comb begin
        step_next        = '0;
        step_next.opcode = op5_reg;
        case (op5_reg)
            OP_ADD_MS, OP_ADD_SEC: begin
                step_next.accepted = 1'b1;
                step_next.hour     = rem_hour[4:0];
                step_next.minute   = dm5_reg;
                step_next.second   = ds5_reg;
                step_next.millis   = dms5_reg;
            end
            OP_LOAD: begin
                step_next.accepted = ld5_reg.ok;
                step_next.hour     = ld5_reg.hour;
                step_next.minute   = ld5_reg.minute;
                step_next.second   = ld5_reg.second;
                step_next.millis   = ld5_reg.millis;
            end
            default: begin
                step_next.accepted = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            vout_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= in_item.opcode;
            amt1_reg <= in_item.delta_amount;
            ld1_reg  <= ld_in;

            op2_reg  <= op1_reg;
            amt2_reg <= amt1_reg;
            qms2_reg <= qms;
            ld2_reg  <= ld1_reg;

            op3_reg  <= op2_reg;
            sec3_reg <= sec_total;
            mq3_reg  <= mq;
            dms3_reg <= dms;
            ld3_reg  <= ld2_reg;

            op4_reg  <= op3_reg;
            mq4_reg  <= mq3_reg;
            hq4_reg  <= hq;
            dms4_reg <= dms3_reg;
            ds4_reg  <= rem_sec[5:0];
            ld4_reg  <= ld3_reg;

            op5_reg  <= op4_reg;
            hq5_reg  <= hq4_reg;
            hd5_reg  <= hd;
            dms5_reg <= dms4_reg;
            ds5_reg  <= ds4_reg;
            dm5_reg  <= rem_min[5:0];
            ld5_reg  <= ld4_reg;

            step_reg <= step_next;
        end
    end

    assign out_valid = vout_reg;
    assign out_step  = step_reg;

endmodule

// ===== hw/rtl/time_of_day_accumulator_core.sv =====
// time_of_day_accumulator_core: top level of the time-of-day accumulator
// depends on tod_pkg and tod_split
//
// Usage:
//   s_valid/s_ready/s_data carries one item: opcode (add ms, add seconds, load),
//   a 31-bit amount and the load fields. Every item yields exactly one result on
//   m_valid/m_ready/m_data: the time after the item, its milliseconds since
//   midnight and an accepted flag (0 for a rejected load or the unused opcode).
//   One item is taken per cycle while the result side keeps up. The item is
//   registered, cut into time digits by four reciprocal-multiply stages and
//   registered as digits, the digits are added to the held time with carries
//   in a single stage, and a last stage forms the result.
//   When the receiver stalls, the whole pipeline holds and s_ready drops until
//   m_data is taken. After aresetn the held time is midnight and no item is in
//   flight.
module time_of_day_accumulator_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tod_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tod_pkg::out_item_t m_data
);
    import tod_pkg::*;

    logic       adv;
    logic       step_valid;
    step_t      step;

    logic [4:0] hour_reg,   hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [9:0] millis_reg, millis_next;

    logic [10:0] ms_sum;
    logic [6:0]  sec_sum;
    logic [6:0]  min_sum;
    logic [5:0]  hour_sum;
    logic        c_ms, c_sec, c_min;
    logic [9:0]  ms_wrap;
    logic [5:0]  sec_wrap;
    logic [5:0]  min_wrap;
    logic [4:0]  hour_wrap;

    logic       u_valid_reg;
    logic [4:0] u_hour_reg;
    logic [5:0] u_minute_reg;
    logic [5:0] u_second_reg;
    logic [9:0] u_millis_reg;
    logic       u_ok_reg;

    logic        m_valid_reg;
    out_item_t   m_data_reg;
    out_item_t   m_data_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    tod_split u_split (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .in_item   (s_data),
        .out_valid (step_valid),
        .out_step  (step)
    );

    // digit adds with carries; for add items every digit sum stays below twice its modulus
    assign ms_sum   = 11'(millis_reg) + 11'(step.millis);
    assign c_ms     = ms_sum >= 11'(MS_PER_SEC);
    assign ms_wrap  = c_ms ? 10'(ms_sum - 11'(MS_PER_SEC)) : ms_sum[9:0];
    assign sec_sum  = 7'(second_reg) + 7'(step.second) + 7'(c_ms);
    assign c_sec    = sec_sum >= 7'(SEC_PER_MIN);
    assign sec_wrap = c_sec ? 6'(sec_sum - 7'(SEC_PER_MIN)) : sec_sum[5:0];
    assign min_sum  = 7'(minute_reg) + 7'(step.minute) + 7'(c_sec);
    assign c_min    = min_sum >= 7'(MIN_PER_HOUR);
    assign min_wrap = c_min ? 6'(min_sum - 7'(MIN_PER_HOUR)) : min_sum[5:0];
    assign hour_sum = 6'(hour_reg) + 6'(step.hour) + 6'(c_min);
    assign hour_wrap = (hour_sum >= 6'(HOURS_PER_DAY)) ?
                       5'(hour_sum - 6'(HOURS_PER_DAY)) : hour_sum[4:0];

    always_comb begin
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        millis_next = millis_reg;
        case (step.opcode)
            OP_ADD_MS, OP_ADD_SEC: begin
                hour_next   = hour_wrap;
                minute_next = min_wrap;
                second_next = sec_wrap;
                millis_next = ms_wrap;
            end
            OP_LOAD: begin
                if (step.accepted) begin
                    hour_next   = step.hour;
                    minute_next = step.minute;
                    second_next = step.second;
                    millis_next = step.millis;
                end
            end
            default: begin
                hour_next = hour_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg    <= '0;
            minute_reg  <= '0;
            second_reg  <= '0;
            millis_reg  <= '0;
            u_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            if (step_valid) begin
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                second_reg <= second_next;
                millis_reg <= millis_next;
            end
            u_valid_reg <= step_valid;
            m_valid_reg <= u_valid_reg;
        end
    end

    always_comb begin
        m_data_next.cur_hour   = u_hour_reg;
        m_data_next.cur_minute = u_minute_reg;
        m_data_next.cur_second = u_second_reg;
        m_data_next.cur_millis = u_millis_reg;
        m_data_next.day_millis = 27'(u_hour_reg) * 27'(MS_PER_HOUR)
                               + 27'(u_minute_reg) * 27'(MS_PER_MIN)
                               + 27'(u_second_reg) * 27'(MS_PER_SEC)
                               + 27'(u_millis_reg);
        m_data_next.accepted   = u_ok_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_hour_reg   <= hour_next;
            u_minute_reg <= minute_next;
            u_second_reg <= second_next;
            u_millis_reg <= millis_next;
            u_ok_reg     <= step.accepted;
            m_data_reg   <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/tod_checker.sv =====
// tod_checker: port-level assertions for time_of_day_accumulator_core, attached by bind
// depends on tod_pkg
module tod_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input tod_pkg::out_item_t m_data
);
    import tod_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // held time is always a legal time of day
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.cur_hour <= 5'(MAX_HOUR)) && (m_data.cur_minute <= 6'(MAX_MINUTE))
                 && (m_data.cur_second <= 6'(MAX_SECOND))
                 && (m_data.cur_millis <= 10'(MAX_MILLIS)))
        else $error("result time out of range");

    // day_millis agrees with the digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.day_millis) == 32'(m_data.cur_hour) * MS_PER_HOUR
                     + 32'(m_data.cur_minute) * MS_PER_MIN
                     + 32'(m_data.cur_second) * MS_PER_SEC + 32'(m_data.cur_millis)))
        else $error("day_millis does not match time digits");

    // a full stalled output blocks new items
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready || !s_valid)
        else $error("item taken while output stalled");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind time_of_day_accumulator_core tod_checker u_tod_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/time_of_day_accumulator_core_tb.sv =====
// time_of_day_accumulator_core_tb: self-checking bench for the time-of-day accumulator core
// drives items on the s_ channel, predicts each result in a local time model and checks m_
// depends on tod_pkg and time_of_day_accumulator_core
`timescale 1ns / 100ps

module time_of_day_accumulator_core_tb;

    import tod_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam longint unsigned SEC_PER_HOUR = SEC_PER_MIN * MIN_PER_HOUR;
    localparam longint unsigned SEC_PER_DAY  = SEC_PER_HOUR * HOURS_PER_DAY;
    localparam longint unsigned MS_PER_DAY   = SEC_PER_DAY * MS_PER_SEC;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // local copy of the held time
    logic [4:0] tod_hour = '0;
    logic [5:0] tod_minute = '0;
    logic [5:0] tod_second = '0;
    logic [9:0] tod_millis = '0;

    in_item_t  pending_items[$];
    out_item_t expected_times[$];
    out_item_t oldest_time;
    bit        item_taken = 1'b0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        mismatch_count = 0;

    time_of_day_accumulator_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("time_of_day_accumulator_core regression: fail");
        $finish;
    end

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        end
    endtask

    function automatic longint unsigned held_seconds();
        return longint'(tod_hour) * SEC_PER_HOUR + longint'(tod_minute) * SEC_PER_MIN
             + longint'(tod_second);
    endfunction

    function automatic void set_clock_seconds(longint unsigned secs);
        longint unsigned day_secs;
        day_secs   = secs % SEC_PER_DAY;
        tod_second = 6'(day_secs % SEC_PER_MIN);
        tod_minute = 6'((day_secs / SEC_PER_MIN) % MIN_PER_HOUR);
        tod_hour   = 5'(day_secs / SEC_PER_HOUR);
    endfunction

    // applies one item to the local time and returns the result it should give
    function automatic out_item_t next_time_of_day(in_item_t item);
        longint unsigned total;
        out_item_t       res;
        logic            ok;
        ok = 1'b0;
        case (item.opcode)
            OP_ADD_MS: begin
                total = (held_seconds() * MS_PER_SEC + tod_millis + item.delta_amount)
                        % MS_PER_DAY;
                tod_millis = 10'(total % MS_PER_SEC);
                set_clock_seconds(total / MS_PER_SEC);
                ok = 1'b1;
            end
            OP_ADD_SEC: begin
                set_clock_seconds(held_seconds() + item.delta_amount);
                ok = 1'b1;
            end
            OP_LOAD: begin
                if (item.load_hour <= MAX_HOUR && item.load_minute <= MAX_MINUTE &&
                    item.load_second <= MAX_SECOND && item.load_millis <= MAX_MILLIS) begin
                    tod_hour   = item.load_hour;
                    tod_minute = item.load_minute;
                    tod_second = item.load_second;
                    tod_millis = item.load_millis;
                    ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.cur_hour   = tod_hour;
        res.cur_minute = tod_minute;
        res.cur_second = tod_second;
        res.cur_millis = tod_millis;
        res.day_millis = 27'(held_seconds() * MS_PER_SEC + tod_millis);
        res.accepted   = ok;
        return res;
    endfunction

    task automatic queue_item(logic [1:0] op, logic [30:0] amount, logic [4:0] hr,
                              logic [5:0] mn, logic [5:0] sc, logic [9:0] ms);
        in_item_t item;
        item.opcode       = op;
        item.delta_amount = amount;
        item.load_hour    = hr;
        item.load_minute  = mn;
        item.load_second  = sc;
        item.load_millis  = ms;
        pending_items.push_back(item);
    endtask

    function automatic in_item_t random_item();
        in_item_t item;
        int       pick;
        int       kind;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 3);
        // ignored fields still carry random content
        item.delta_amount = 31'($urandom);
        item.load_hour    = 5'($urandom);
        item.load_minute  = 6'($urandom);
        item.load_second  = 6'($urandom);
        item.load_millis  = 10'($urandom);
        if (pick < 38) begin
            item.opcode = OP_ADD_MS;
            case (kind)
                0: item.delta_amount = 31'($urandom_range(0, 1999));
                1: item.delta_amount = 31'($urandom_range(0, 2 * MS_PER_DAY));
                2: item.delta_amount = 31'($urandom);
                default: item.delta_amount =
                    31'(longint'($urandom_range(1, 24)) * MS_PER_DAY - $urandom_range(0, 3000));
            endcase
        end else if (pick < 70) begin
            item.opcode = OP_ADD_SEC;
            case (kind)
                0: item.delta_amount = 31'($urandom_range(0, 120));
                1: item.delta_amount = 31'($urandom_range(0, 3 * SEC_PER_DAY));
                2: item.delta_amount = 31'($urandom);
                default: item.delta_amount =
                    31'(longint'($urandom_range(1, 24000)) * SEC_PER_DAY - $urandom_range(0, 90));
            endcase
        end else if (pick < 90) begin
            item.opcode      = OP_LOAD;
            item.load_hour   = 5'($urandom_range(0, MAX_HOUR));
            item.load_minute = 6'($urandom_range(0, MAX_MINUTE));
            item.load_second = 6'($urandom_range(0, MAX_SECOND));
            item.load_millis = 10'($urandom_range(0, MAX_MILLIS));
            // land just short of a carry now and then
            if (kind == 0) begin
                item.load_second = 6'(MAX_SECOND);
                item.load_millis = 10'($urandom_range(MAX_MILLIS - 20, MAX_MILLIS));
            end
        end else if (pick < 96) begin
            item.opcode      = OP_LOAD;
            item.load_hour   = 5'($urandom_range(0, MAX_HOUR));
            item.load_minute = 6'($urandom_range(0, MAX_MINUTE));
            item.load_second = 6'($urandom_range(0, MAX_SECOND));
            item.load_millis = 10'($urandom_range(0, MAX_MILLIS));
            case (kind)
                0: item.load_hour   = 5'($urandom_range(MAX_HOUR + 1, 31));
                1: item.load_minute = 6'($urandom_range(MAX_MINUTE + 1, 63));
                2: item.load_second = 6'($urandom_range(MAX_SECOND + 1, 63));
                default: item.load_millis = 10'($urandom_range(MAX_MILLIS + 1, 1023));
            endcase
        end else begin
            item.opcode = OP_UNUSED;
        end
        return item;
    endfunction

    task automatic wait_until_drained();
        while (pending_items.size() != 0 || s_valid || expected_times.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // sender side and receiver ready, both moved on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            item_taken = 1'b0;
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_times.push_back(next_time_of_day(s_data));
                item_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_times.size() == 0) begin
                    flag_mismatch("result with nothing expected", m_data, 0);
                end else begin
                    oldest_time = expected_times.pop_front();
                    if (m_data.cur_hour != oldest_time.cur_hour)
                        flag_mismatch("cur_hour", m_data.cur_hour, oldest_time.cur_hour);
                    if (m_data.cur_minute != oldest_time.cur_minute)
                        flag_mismatch("cur_minute", m_data.cur_minute, oldest_time.cur_minute);
                    if (m_data.cur_second != oldest_time.cur_second)
                        flag_mismatch("cur_second", m_data.cur_second, oldest_time.cur_second);
                    if (m_data.cur_millis != oldest_time.cur_millis)
                        flag_mismatch("cur_millis", m_data.cur_millis, oldest_time.cur_millis);
                    if (m_data.day_millis != oldest_time.day_millis)
                        flag_mismatch("day_millis", m_data.day_millis, oldest_time.day_millis);
                    if (m_data.accepted != oldest_time.accepted)
                        flag_mismatch("accepted", m_data.accepted, oldest_time.accepted);
                end
            end
        end
    end

    initial begin
        // directed: extremes, wraps, every invalid field, unused opcode, ignored fields
        queue_item(OP_ADD_MS, 31'd0, 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_LOAD, 31'd0, 5'd23, 6'd59, 6'd59, 10'd999);
        queue_item(OP_ADD_MS, 31'd1, 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_LOAD, 31'h7fffffff, 5'd23, 6'd59, 6'd59, 10'd999);
        queue_item(OP_ADD_SEC, 31'd1, 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_ADD_MS, 31'h7fffffff, 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_ADD_SEC, 31'h7fffffff, 5'h1f, 6'h3f, 6'h3f, 10'h3ff);
        queue_item(OP_LOAD, 31'h7fffffff, 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_LOAD, 31'd0, 5'd24, 6'd10, 6'd10, 10'd10);
        queue_item(OP_LOAD, 31'd0, 5'd31, 6'd10, 6'd10, 10'd10);
        queue_item(OP_LOAD, 31'd0, 5'd10, 6'd60, 6'd10, 10'd10);
        queue_item(OP_LOAD, 31'd0, 5'd10, 6'd63, 6'd10, 10'd10);
        queue_item(OP_LOAD, 31'd0, 5'd10, 6'd10, 6'd60, 10'd10);
        queue_item(OP_LOAD, 31'd0, 5'd10, 6'd10, 6'd63, 10'd10);
        queue_item(OP_LOAD, 31'd0, 5'd10, 6'd10, 6'd10, 10'd1000);
        queue_item(OP_LOAD, 31'd0, 5'd10, 6'd10, 6'd10, 10'd1023);
        queue_item(OP_UNUSED, 31'h7fffffff, 5'h1f, 6'h3f, 6'h3f, 10'h3ff);
        queue_item(OP_LOAD, 31'd5, 5'd12, 6'd34, 6'd56, 10'd789);
        queue_item(OP_ADD_SEC, 31'd0, 5'h1f, 6'h3f, 6'h3f, 10'h3ff);
        queue_item(OP_ADD_MS, 31'(MS_PER_DAY), 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_ADD_SEC, 31'(SEC_PER_DAY), 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_ADD_MS, 31'd999, 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_ADD_MS, 31'(MS_PER_DAY - 1), 5'd0, 6'd0, 6'd0, 10'd0);
        queue_item(OP_UNUSED, 31'd0, 5'd0, 6'd0, 6'd0, 10'd0);

        send_idle_pct = 24;
        recv_idle_pct = 82;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        repeat (520) pending_items.push_back(random_item());
        // sender holds off here until every result is back
        wait_until_drained();

        send_idle_pct = 82;
        recv_idle_pct = 24;
        repeat (520) pending_items.push_back(random_item());
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (510) pending_items.push_back(random_item());
        wait_until_drained();

        repeat (16) @(posedge aclk);
        if (expected_times.size() != 0) begin
            flag_mismatch("results never returned", 0, expected_times.size());
        end
        if (mismatch_count == 0) begin
            $display("time_of_day_accumulator_core regression: pass");
        end else begin
            $display("time_of_day_accumulator_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tod_pkg.sv
hw/rtl/tod_split.sv
hw/rtl/time_of_day_accumulator_core.sv
hw/rtl/tod_checker.sv
dv/time_of_day_accumulator_core_tb.sv
